// ----- sv/grc_pkg.sv -----
// shared types and constants for the gamepad report conditioner
package grc_pkg;

    localparam int SLOT_COUNT     = 4;
    localparam int USER_W         = 2;
    localparam int BTN_IN_W       = 12;
    localparam int MASK_W         = 14;
    localparam int STICK_IN_W     = 18;
    localparam int TRIG_IN_W      = 17;
    localparam int STICK_OUT_W    = 9;
    localparam int TRIG_OUT_W     = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 8;

    localparam logic [CFG_DATA_W-1:0] TRIG_ON_RESET  = 8'd128;
    localparam logic [CFG_DATA_W-1:0] TRIG_OFF_RESET = 8'd64;

    // register indexes: on thresholds first, then off thresholds
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_ON_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_OFF_0 = 3'd4;

    // held mask bit positions
    localparam int BIT_UP     = 0;
    localparam int BIT_DOWN   = 1;
    localparam int BIT_LEFT   = 2;
    localparam int BIT_RIGHT  = 3;
    localparam int BIT_TRIG_L = 12;
    localparam int BIT_TRIG_R = 13;

    typedef logic [MASK_W-1:0] t_mask;

    typedef enum logic [1:0] {
        DEV_NONE   = 2'd0,
        DEV_PAD    = 2'd1,
        DEV_RUMBLE = 2'd2
    } t_dev;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] on_lvl;
        logic [CFG_DATA_W-1:0] off_lvl;
    } t_thresh;

    typedef struct packed {
        t_mask held;
        t_mask pressed;
        t_mask released;
    } t_btn_masks;

endpackage

// ----- sv/gamepad_report_conditioner_core.sv -----
// Gamepad report conditioner top level: one pad sample in, one report out.
// A beat is registered on input, conditioned from the input register and
// registered on output once the output register is free or its report is
// taken; the report is offered from the output register. A new sample can be
// taken every cycle while reports are taken; a stalled report holds the input
// once the input register is full as well. The per-user held mask is
// updated as a report is loaded, so consecutive beats for the same user see
// each other's state. Threshold writes are taken at any time (cfg ready is
// always high) and should only be made while no beat is in flight.
module gamepad_report_conditioner_core
    import grc_pkg::*;
#(
    parameter int USER_COUNT = SLOT_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [USER_W-1:0]             i_user,
    input  logic                          i_connected,
    input  logic                          i_rumble_capable,
    input  logic signed [STICK_IN_W-1:0]  i_stick_left_x,
    input  logic signed [STICK_IN_W-1:0]  i_stick_left_y,
    input  logic signed [STICK_IN_W-1:0]  i_stick_right_x,
    input  logic signed [STICK_IN_W-1:0]  i_stick_right_y,
    input  logic [TRIG_IN_W-1:0]          i_trigger_right_in,
    input  logic [TRIG_IN_W-1:0]          i_trigger_left_in,
    input  logic [BTN_IN_W-1:0]           i_user_buttons,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [STICK_OUT_W-1:0] o_pad_left_x,
    output logic signed [STICK_OUT_W-1:0] o_pad_left_y,
    output logic signed [STICK_OUT_W-1:0] o_pad_right_x,
    output logic signed [STICK_OUT_W-1:0] o_pad_right_y,
    output logic [TRIG_OUT_W-1:0]         o_pad_trigger_right,
    output logic [TRIG_OUT_W-1:0]         o_pad_trigger_left,
    output logic [MASK_W-1:0]             o_held_mask,
    output logic [MASK_W-1:0]             o_pressed_mask,
    output logic [MASK_W-1:0]             o_released_mask,
    output logic [1:0]                    o_device_type,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int UW = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;

    // input stage
    logic                          r_s1_vld;
    logic [USER_W-1:0]             r_s1_user;
    logic                          r_s1_conn;
    logic                          r_s1_rumble;
    logic signed [STICK_IN_W-1:0]  r_s1_lx, r_s1_ly, r_s1_rx, r_s1_ry;
    logic [TRIG_IN_W-1:0]          r_s1_tr, r_s1_tl;
    logic [BTN_IN_W-1:0]           r_s1_btn;

    // held mask store
    t_mask r_last_held [USER_COUNT];

    // output stage
    logic                          r_out_vld;
    logic signed [STICK_OUT_W-1:0] r_lx, r_ly, r_rx, r_ry;
    logic [TRIG_OUT_W-1:0]         r_tr, r_tl;
    t_btn_masks                    r_masks;
    t_dev                          r_dev;

    logic                          in_fire;
    logic                          s1_adv;
    logic                          user_ok;
    logic                          active;
    t_mask                         old_held;
    t_thresh                       thresh;
    t_btn_masks                    masks;
    logic signed [STICK_OUT_W-1:0] sc_lx, sc_ly, sc_rx, sc_ry;
    logic [TRIG_OUT_W-1:0]         sc_tr, sc_tl;

    logic signed [STICK_OUT_W-1:0] n_lx, n_ly, n_rx, n_ry;
    logic [TRIG_OUT_W-1:0]         n_tr, n_tl;
    t_btn_masks                    n_masks;
    t_dev                          n_dev;

    assign s1_adv      = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_s1_vld || s1_adv;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    grc_thresh_regs #(
        .USER_COUNT (USER_COUNT)
    ) u_thresh (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rd_user   (r_s1_user),
        .o_thresh    (thresh)
    );

    grc_scaler u_scaler (
        .i_stick_left_x      (r_s1_lx),
        .i_stick_left_y      (r_s1_ly),
        .i_stick_right_x     (r_s1_rx),
        .i_stick_right_y     (r_s1_ry),
        .i_trigger_right_in  (r_s1_tr),
        .i_trigger_left_in   (r_s1_tl),
        .o_pad_left_x        (sc_lx),
        .o_pad_left_y        (sc_ly),
        .o_pad_right_x       (sc_rx),
        .o_pad_right_y       (sc_ry),
        .o_pad_trigger_right (sc_tr),
        .o_pad_trigger_left  (sc_tl)
    );

    assign user_ok  = (32'(r_s1_user) < USER_COUNT);
    assign active   = user_ok && r_s1_conn;
    assign old_held = r_last_held[r_s1_user[UW-1:0]];

    grc_button_logic u_buttons (
        .i_user_buttons (r_s1_btn),
        .i_trig_left    (sc_tl),
        .i_trig_right   (sc_tr),
        .i_thresh       (thresh),
        .i_old          (old_held),
        .o_masks        (masks)
    );

    always_comb begin
        n_lx    = '0;
        n_ly    = '0;
        n_rx    = '0;
        n_ry    = '0;
        n_tr    = '0;
        n_tl    = '0;
        n_masks = '0;
        n_dev   = DEV_NONE;
        if (active) begin
            n_lx    = sc_lx;
            n_ly    = sc_ly;
            n_rx    = sc_rx;
            n_ry    = sc_ry;
            n_tr    = sc_tr;
            n_tl    = sc_tl;
            n_masks = masks;
            n_dev   = r_s1_rumble ? DEV_RUMBLE : DEV_PAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < USER_COUNT; i++) begin
                r_last_held[i] <= '0;
            end
        end else begin
            if (in_fire) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (s1_adv && user_ok) begin
                r_last_held[r_s1_user[UW-1:0]] <= r_s1_conn ? masks.held : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_user   <= i_user;
            r_s1_conn   <= i_connected;
            r_s1_rumble <= i_rumble_capable;
            r_s1_lx     <= i_stick_left_x;
            r_s1_ly     <= i_stick_left_y;
            r_s1_rx     <= i_stick_right_x;
            r_s1_ry     <= i_stick_right_y;
            r_s1_tr     <= i_trigger_right_in;
            r_s1_tl     <= i_trigger_left_in;
            r_s1_btn    <= i_user_buttons;
        end
        if (s1_adv) begin
            r_lx    <= n_lx;
            r_ly    <= n_ly;
            r_rx    <= n_rx;
            r_ry    <= n_ry;
            r_tr    <= n_tr;
            r_tl    <= n_tl;
            r_masks <= n_masks;
            r_dev   <= n_dev;
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_pad_left_x        = r_lx;
    assign o_pad_left_y        = r_ly;
    assign o_pad_right_x       = r_rx;
    assign o_pad_right_y       = r_ry;
    assign o_pad_trigger_right = r_tr;
    assign o_pad_trigger_left  = r_tl;
    assign o_held_mask         = r_masks.held;
    assign o_pressed_mask      = r_masks.pressed;
    assign o_released_mask     = r_masks.released;
    assign o_device_type       = r_dev;

    // opposite d-pad directions never both held
    a_dpad_cancel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_held_mask[BIT_UP] && o_held_mask[BIT_DOWN])
                        && !(o_held_mask[BIT_LEFT] && o_held_mask[BIT_RIGHT]))
        else $error("d-pad pair both held");

    a_edges_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_pressed_mask & o_released_mask) == '0)
                        && ((o_pressed_mask & ~o_held_mask) == '0)
                        && ((o_released_mask & o_held_mask) == '0))
        else $error("edge masks inconsistent with held mask");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_device_type == DEV_NONE)) |->
            (o_held_mask == '0) && (o_pressed_mask == '0)
            && (o_pad_trigger_left == '0) && (o_pad_trigger_right == '0))
        else $error("report for absent user not cleared");

    // a report loaded from a disconnected slot leaves that slot's mask cleared
    a_disc_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && user_ok && !r_s1_conn) |=>
            (r_last_held[$past(r_s1_user[UW-1:0])] == '0))
        else $error("held mask not cleared on disconnect");

endmodule

// ----- sv/grc_thresh_regs.sv -----
// per-user trigger on/off threshold registers with config write decode
module grc_thresh_regs
    import grc_pkg::*;
#(
    parameter int USER_COUNT = SLOT_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [USER_W-1:0]     i_rd_user,
    output t_thresh               o_thresh
);

    localparam int UW = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;

    logic [CFG_DATA_W-1:0] r_on  [USER_COUNT];
    logic [CFG_DATA_W-1:0] r_off [USER_COUNT];

    logic                 wr_off;
    logic [CFG_IDX_W-1:0] slot_full;
    logic [USER_W-1:0]    slot;

    always_comb begin
        wr_off    = (i_cfg_index >= CFG_TRIG_OFF_0);
        slot_full = wr_off ? (i_cfg_index - CFG_TRIG_OFF_0) : (i_cfg_index - CFG_TRIG_ON_0);
        slot      = slot_full[USER_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < USER_COUNT; i++) begin
                r_on[i]  <= TRIG_ON_RESET;
                r_off[i] <= TRIG_OFF_RESET;
            end
        end else if (i_cfg_wr && (32'(slot) < USER_COUNT)) begin
            if (wr_off) begin
                r_off[slot[UW-1:0]] <= i_cfg_data;
            end else begin
                r_on[slot[UW-1:0]] <= i_cfg_data;
            end
        end
    end

    assign o_thresh.on_lvl  = r_on[i_rd_user[UW-1:0]];
    assign o_thresh.off_lvl = r_off[i_rd_user[UW-1:0]];

endmodule

// ----- sv/grc_scaler.sv -----
// stick and trigger scaling with truncation and saturation
module grc_scaler
    import grc_pkg::*;
(
    input  logic signed [STICK_IN_W-1:0]  i_stick_left_x,
    input  logic signed [STICK_IN_W-1:0]  i_stick_left_y,
    input  logic signed [STICK_IN_W-1:0]  i_stick_right_x,
    input  logic signed [STICK_IN_W-1:0]  i_stick_right_y,
    input  logic        [TRIG_IN_W-1:0]   i_trigger_right_in,
    input  logic        [TRIG_IN_W-1:0]   i_trigger_left_in,
    output logic signed [STICK_OUT_W-1:0] o_pad_left_x,
    output logic signed [STICK_OUT_W-1:0] o_pad_left_y,
    output logic signed [STICK_OUT_W-1:0] o_pad_right_x,
    output logic signed [STICK_OUT_W-1:0] o_pad_right_y,
    output logic        [TRIG_OUT_W-1:0]  o_pad_trigger_right,
    output logic        [TRIG_OUT_W-1:0]  o_pad_trigger_left
);

    // divide by 512 toward zero, clamp to -128..128
    function automatic logic signed [STICK_OUT_W-1:0] f_stick(
        input logic signed [STICK_IN_W-1:0] v
    );
        logic signed [STICK_IN_W:0]  b;
        logic signed [STICK_OUT_W:0] q;
        b = v[STICK_IN_W-1] ? ({v[STICK_IN_W-1], v} + 19'sd511) : {v[STICK_IN_W-1], v};
        q = b[STICK_IN_W:9];
        if (q > 10'sd128) begin
            return 9'sd128;
        end else if (q < -10'sd128) begin
            return -9'sd128;
        end
        return q[STICK_OUT_W-1:0];
    endfunction

    // floor(v * 255 / 65536), clamp to 255
    function automatic logic [TRIG_OUT_W-1:0] f_trig(input logic [TRIG_IN_W-1:0] v);
        logic [TRIG_IN_W+7:0] p;
        logic [TRIG_OUT_W:0]  r;
        p = {v, 8'b0} - {8'b0, v};
        r = p[TRIG_IN_W+7:16];
        if (r[TRIG_OUT_W]) begin
            return '1;
        end
        return r[TRIG_OUT_W-1:0];
    endfunction

    assign o_pad_left_x        = f_stick(i_stick_left_x);
    assign o_pad_left_y        = f_stick(i_stick_left_y);
    assign o_pad_right_x       = f_stick(i_stick_right_x);
    assign o_pad_right_y       = f_stick(i_stick_right_y);
    assign o_pad_trigger_right = f_trig(i_trigger_right_in);
    assign o_pad_trigger_left  = f_trig(i_trigger_left_in);

endmodule

// ----- sv/grc_button_logic.sv -----
// trigger hysteresis, d-pad cancel and edge masks against the stored held mask
module grc_button_logic
    import grc_pkg::*;
(
    input  logic [BTN_IN_W-1:0]   i_user_buttons,
    input  logic [TRIG_OUT_W-1:0] i_trig_left,
    input  logic [TRIG_OUT_W-1:0] i_trig_right,
    input  t_thresh               i_thresh,
    input  t_mask                 i_old,
    output t_btn_masks            o_masks
);

    t_mask held;

    always_comb begin
        held = {2'b00, i_user_buttons};
        if (i_old[BIT_TRIG_L] ? (i_trig_left > i_thresh.off_lvl)
                              : (i_trig_left >= i_thresh.on_lvl)) begin
            held[BIT_TRIG_L] = 1'b1;
        end
        if (i_old[BIT_TRIG_R] ? (i_trig_right > i_thresh.off_lvl)
                              : (i_trig_right >= i_thresh.on_lvl)) begin
            held[BIT_TRIG_R] = 1'b1;
        end
        if (held[BIT_UP] && held[BIT_DOWN]) begin
            held[BIT_UP]   = 1'b0;
            held[BIT_DOWN] = 1'b0;
        end
        if (held[BIT_LEFT] && held[BIT_RIGHT]) begin
            held[BIT_LEFT]  = 1'b0;
            held[BIT_RIGHT] = 1'b0;
        end
        o_masks.held     = held;
        o_masks.pressed  = held & ~i_old;
        o_masks.released = i_old & ~held;
    end

endmodule
